// ===== rtl/acpm_pkg.sv =====
package acpm_pkg;

  // build-time sizing
  localparam int ADC_BITS       = 10;
  localparam int MAX_WINDOWS    = 32;
  localparam int GAIN_FRAC_BITS = 8;

  localparam int TRIG_W    = ADC_BITS - 1;
  localparam int WPR_W     = 8;
  localparam int GAIN_W    = 16;
  localparam int READING_W = 16;
  localparam int CFG_W     = (ADC_BITS > GAIN_W) ? ADC_BITS : GAIN_W;
  localparam int CFG_IDX_W = 2;

  // largest sum is MAX_WINDOWS full-scale half swings
  localparam int SUM_W  = $clog2(MAX_WINDOWS * ((1 << TRIG_W) - 1) + 1);
  localparam int CNT_W  = $clog2(MAX_WINDOWS + 1);
  localparam int PROD_W = SUM_W + GAIN_W;
  localparam int QUO_W  = PROD_W - GAIN_FRAC_BITS;
  localparam int ITER_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;
  localparam int EXT_W  = (QUO_W > READING_W) ? QUO_W : READING_W;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [ADC_BITS-1:0]  MID_RESET  = ADC_BITS'(512);
  localparam logic [TRIG_W-1:0]    TRIG_RESET = '0;
  localparam logic [WPR_W-1:0]     WPR_RESET  = WPR_W'(1);
  localparam logic [GAIN_W-1:0]    GAIN_RESET = GAIN_W'(256);
  localparam logic [READING_W-1:0] READING_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MID  = 2'd0,
    CFG_TRIG = 2'd1,
    CFG_WPR  = 2'd2,
    CFG_GAIN = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] mid;
    logic [TRIG_W-1:0]   trig;
    logic [WPR_W-1:0]    wpr;
    logic [GAIN_W-1:0]   gain;
  } meter_cfg_t;

  // one finished reading waiting for scale and divide
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  count;
    logic [GAIN_W-1:0] gain;
  } job_t;

  // queue handshake towards both sides
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

// ===== rtl/acpm_front.sv =====
module acpm_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [acpm_pkg::ADC_BITS-1:0]  in_sample,
  input  logic                           in_window_end,
  output logic                           in_stall,
  input  acpm_pkg::meter_cfg_t           cfg,
  input  acpm_pkg::q_stat_t              q_stat,
  output logic                           push,
  output acpm_pkg::job_t                 push_job
);
  import acpm_pkg::*;

  logic [ADC_BITS-1:0] min_r, min_nxt, max_r, max_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    done_r, done_nxt;

  logic                accept;
  logic [ADC_BITS-1:0] lo, hi, diff;
  logic [TRIG_W-1:0]   amp, amp_net;
  logic [SUM_W-1:0]    sum_add;
  logic [CNT_W-1:0]    done_inc, count;
  logic                in_range;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  assign in_range = (cfg.wpr >= WPR_W'(1)) && (32'(cfg.wpr) <= 32'(MAX_WINDOWS));
  assign count    = in_range ? CNT_W'(cfg.wpr) : CNT_W'(1);

  always_comb begin
    lo       = (in_sample < min_r) ? in_sample : min_r;
    hi       = (in_sample > max_r) ? in_sample : max_r;
    diff     = hi - lo;
    amp      = diff[ADC_BITS-1:1];
    amp_net  = (amp > cfg.trig) ? amp - cfg.trig : '0;
    sum_add  = sum_r + SUM_W'(amp_net);
    done_inc = done_r + CNT_W'(1);

    min_nxt  = min_r;
    max_nxt  = max_r;
    sum_nxt  = sum_r;
    done_nxt = done_r;
    push     = 1'b0;
    push_job = '{sum: sum_add, count: count, gain: cfg.gain};

    if (accept) begin
      min_nxt = lo;
      max_nxt = hi;
      if (in_window_end) begin
        min_nxt = cfg.mid;
        max_nxt = cfg.mid;
        if (done_inc >= count) begin
          push     = 1'b1;
          sum_nxt  = '0;
          done_nxt = '0;
        end else begin
          sum_nxt  = sum_add;
          done_nxt = done_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= MID_RESET;
      max_r  <= MID_RESET;
      sum_r  <= '0;
      done_r <= '0;
    end else begin
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      sum_r  <= sum_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

// ===== rtl/acpm_queue.sv =====
module acpm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  acpm_pkg::job_t    push_job,
  input  logic              pop,
  output acpm_pkg::job_t    pop_job,
  output acpm_pkg::q_stat_t q_stat
);
  import acpm_pkg::*;

  job_t              slot_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_stat.full  = (cnt_r == QCNT_W'(Q_DEPTH));
  assign q_stat.valid = (cnt_r != '0);
  assign pop_job      = slot_r[rd_r];

  // drop a push into a full queue; the front never does so
  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && q_stat.valid;

  always_comb begin
    wr_nxt  = do_push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/acpm_back.sv =====
module acpm_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  acpm_pkg::q_stat_t               q_stat,
  input  acpm_pkg::job_t                  pop_job,
  output logic                            pop,
  output logic                            out_valid,
  output logic [acpm_pkg::READING_W-1:0]  out_reading,
  input  logic                            out_stall
);
  import acpm_pkg::*;

  back_state_t          state_r, state_nxt;
  job_t                 job_r, job_nxt;
  logic [QUO_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [ITER_W-1:0]    iter_r, iter_nxt;
  logic                 vld_r, vld_nxt;
  logic [READING_W-1:0] rdg_r, rdg_nxt;

  logic [PROD_W-1:0]    prod;
  logic [CNT_W:0]       rem_sh;
  logic                 ge;
  logic [EXT_W-1:0]     quo_ext;
  logic [READING_W-1:0] sat;
  logic                 out_free;

  assign out_valid   = vld_r;
  assign out_reading = rdg_r;
  assign out_free    = !vld_r || !out_stall;

  assign prod    = PROD_W'(job_r.sum) * PROD_W'(job_r.gain);
  assign rem_sh  = {rem_r, quo_r[QUO_W-1]};
  assign ge      = rem_sh >= {1'b0, job_r.count};
  assign quo_ext = EXT_W'(quo_r);
  assign sat     = (quo_ext > EXT_W'(READING_MAX)) ? READING_MAX : quo_ext[READING_W-1:0];

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    iter_nxt  = iter_r;
    rdg_nxt   = rdg_r;
    vld_nxt   = vld_r && out_stall;
    pop       = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        if (q_stat.valid) begin
          pop       = 1'b1;
          job_nxt   = pop_job;
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: begin
        // scale, drop the gain fraction, then divide by the window count
        quo_nxt   = prod[PROD_W-1:GAIN_FRAC_BITS];
        rem_nxt   = '0;
        iter_nxt  = '0;
        state_nxt = BK_DIV;
      end
      BK_DIV: begin
        rem_nxt  = ge ? CNT_W'(rem_sh - {1'b0, job_r.count}) : rem_sh[CNT_W-1:0];
        quo_nxt  = {quo_r[QUO_W-2:0], ge};
        iter_nxt = iter_r + ITER_W'(1);
        if (iter_r == ITER_W'(QUO_W - 1)) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          rdg_nxt   = sat;
          vld_nxt   = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    iter_r <= iter_nxt;
    rdg_r  <= rdg_nxt;
  end

endmodule

// ===== rtl/ac_current_peak_meter_unit.sv =====
// Peak-to-peak AC current meter. Each input word is one ADC sample; window_end marks
// the last sample of a measurement window. Per window the running min and max start
// at mid_level, and the half swing less trigger_level (floored at zero) is summed.
// After windows_per_reading windows (values outside 1..32 count as 1) one reading of
// floor(sum * gain / (count * 256)) is emitted, saturated at 65535; gain is unsigned
// Q8.8. Samples are taken one per clock. A reading then passes a two-entry queue
// into the arithmetic back end, which fetches it, multiplies, divides with a restoring
// divider that yields one quotient bit per cycle, and loads the output register; it
// takes the next reading only after that. Input stalls only while the queue is full,
// so window ends that come faster than the back end drains are absorbed two deep.
// Configuration writes are taken at any time but belong to idle periods.
module ac_current_peak_meter_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [acpm_pkg::ADC_BITS-1:0]   in_sample,
  input  logic                            in_window_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [acpm_pkg::READING_W-1:0]  out_reading,
  input  logic                            cfg_we,
  input  logic [acpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acpm_pkg::CFG_W-1:0]      cfg_data
);
  import acpm_pkg::*;

  // configuration register bank
  meter_cfg_t cfg_r, cfg_nxt;

  q_stat_t q_stat;
  logic    push, pop;
  job_t    push_job, pop_job;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MID:  cfg_nxt.mid  = cfg_data[ADC_BITS-1:0];
        CFG_TRIG: cfg_nxt.trig = cfg_data[TRIG_W-1:0];
        CFG_WPR:  cfg_nxt.wpr  = cfg_data[WPR_W-1:0];
        CFG_GAIN: cfg_nxt.gain = cfg_data[GAIN_W-1:0];
        default:  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{mid: MID_RESET, trig: TRIG_RESET, wpr: WPR_RESET, gain: GAIN_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end: track min and max, close windows, hand finished sums on
  acpm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_sample     (in_sample),
    .in_window_end (in_window_end),
    .in_stall      (in_stall),
    .cfg           (cfg_r),
    .q_stat        (q_stat),
    .push          (push),
    .push_job      (push_job)
  );

  // hold finished sums, gain and count captured at window end
  acpm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  // back end: scale, divide, saturate, present the word
  acpm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .pop_job     (pop_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_reading (out_reading),
    .out_stall   (out_stall)
  );

endmodule

// ===== rtl/acpm_checker.sv =====
module acpm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [acpm_pkg::READING_W-1:0] out_reading
);
  import acpm_pkg::*;

  // a stalled reading holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_reading))
    else $error("stalled reading changed or dropped");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("reading valid straight after reset");

  // reset empties the queue, so the input side is open
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled straight after reset");

  // a reading needs the multiply and divide, never appears just after reset
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3))
    else $error("reading appeared too soon after reset");

endmodule

bind ac_current_peak_meter_unit acpm_checker u_acpm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_reading (out_reading)
);

// ===== dv/tb.sv =====
module tb;
  import acpm_pkg::*;

  // Predicts readings from accepted sample words and checks the block's output
  // against them in order of arrival.
  class meter_scoreboard;
    logic [ADC_BITS-1:0]  mid;
    logic [TRIG_W-1:0]    trig;
    logic [WPR_W-1:0]     wpr;
    logic [GAIN_W-1:0]    gain;
    logic [ADC_BITS-1:0]  win_lo;
    logic [ADC_BITS-1:0]  win_hi;
    int unsigned          amp_sum;
    int unsigned          windows_seen;
    logic [READING_W-1:0] readings_due[$];
    int unsigned          mismatches;
    int unsigned          words_in;
    int unsigned          window_ends;
    int unsigned          readings_out;
    int unsigned          saturated;
    int unsigned          zero_readings;

    function new();
      mid           = MID_RESET;
      trig          = TRIG_RESET;
      wpr           = WPR_RESET;
      gain          = GAIN_RESET;
      win_lo        = MID_RESET;
      win_hi        = MID_RESET;
      amp_sum       = 0;
      windows_seen  = 0;
      mismatches    = 0;
      words_in      = 0;
      window_ends   = 0;
      readings_out  = 0;
      saturated     = 0;
      zero_readings = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_MID:  mid  = val[ADC_BITS-1:0];
        CFG_TRIG: trig = val[TRIG_W-1:0];
        CFG_WPR:  wpr  = val[WPR_W-1:0];
        CFG_GAIN: gain = val[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [ADC_BITS-1:0] s, logic last);
      int unsigned       half;
      int unsigned       divisor;
      longint unsigned   scaled;
      words_in++;
      if (s < win_lo) win_lo = s;
      if (s > win_hi) win_hi = s;
      if (!last) return;
      window_ends++;
      half = (int'(win_hi) - int'(win_lo)) >> 1;
      half = (half > trig) ? half - trig : 0;
      amp_sum += half;
      windows_seen++;
      // next window opens at the current midpoint
      win_lo = mid;
      win_hi = mid;
      divisor = (wpr >= 1 && wpr <= MAX_WINDOWS) ? wpr : 1;
      if (windows_seen < divisor) return;
      scaled = (longint'(amp_sum) * longint'(gain)) / (longint'(divisor) << GAIN_FRAC_BITS);
      if (scaled > READING_MAX) scaled = READING_MAX;
      if (scaled == READING_MAX) saturated++;
      if (scaled == 0) zero_readings++;
      readings_due.push_back(scaled[READING_W-1:0]);
      amp_sum      = 0;
      windows_seen = 0;
    endfunction

    function void check_reading(logic [READING_W-1:0] got);
      logic [READING_W-1:0] want;
      readings_out++;
      if (readings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("reading %0d arrived with none outstanding", got);
        return;
      end
      want = readings_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("reading mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [ADC_BITS-1:0]  in_sample;
  logic                 in_window_end;
  logic                 out_valid;
  logic                 out_stall;
  logic [READING_W-1:0] out_reading;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  meter_scoreboard sb;

  // idling controls, percent per cycle
  int send_idle_pct;
  int stall_pct;
  // long receiver hold-off, counted down by the receiver process
  int hold_left;
  int words_sent;

  ac_current_peak_meter_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .in_window_end (in_window_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_reading   (out_reading),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: stall at random, or hold off for a long stretch when asked.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Sample both handshakes at the rising edge; feed the predictor, then check.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_sample(in_sample, in_window_end);
      if (out_valid && !out_stall) sb.check_reading(out_reading);
    end
  end

  // Offer one sample word; return at the falling edge after it is taken.
  task automatic send_word(input logic [ADC_BITS-1:0] s, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_sample     <= s;
    in_window_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Write all four registers on consecutive cycles; keep the predictor in step.
  task automatic set_config(input int unsigned m, input int unsigned t,
                            input int unsigned w, input int unsigned g);
    cfg_reg_t idx;
    int unsigned vals[4];
    vals = '{m, t, w, g};
    for (int i = 0; i < 4; i++) begin
      idx = cfg_reg_t'(i);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[i][CFG_W-1:0];
      sb.set_reg(idx, vals[i][CFG_W-1:0]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid, wait for every outstanding reading, then let the back end go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.readings_due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // One well-formed window around the midpoint; the last word closes it.
  task automatic send_window();
    int len;
    int swing;
    int v;
    len   = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
    swing = $urandom_range(511);
    for (int i = 0; i < len; i++) begin
      v = int'(sb.mid) + int'($urandom_range(2 * swing)) - swing;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      send_word(v[ADC_BITS-1:0], i == len - 1);
    end
  endtask

  task automatic random_config();
    int unsigned m;
    int unsigned t;
    int unsigned w;
    int unsigned g;
    case ($urandom_range(3))
      0:       m = 0;
      1:       m = 1023;
      2:       m = 512;
      default: m = $urandom_range(1023);
    endcase
    case ($urandom_range(4))
      0:       t = 0;
      1:       t = 511;
      2, 3:    t = $urandom_range(40);
      default: t = $urandom_range(511);
    endcase
    // counts above the range and zero both fall back to a single window
    case ($urandom_range(7))
      0:       w = 0;
      1:       w = MAX_WINDOWS;
      2:       w = $urandom_range(MAX_WINDOWS + 1, 254);
      3:       w = 255;
      4, 5:    w = 1;
      default: w = $urandom_range(1, 6);
    endcase
    case ($urandom_range(3))
      0:       g = 65535;
      1:       g = 256;
      2:       g = $urandom_range(65535);
      default: g = $urandom_range(1, 1024);
    endcase
    set_config(m, t, w, g);
  endtask

  initial begin
    int phase_words;
    int phase;
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_sample     = '0;
    in_window_end = 1'b0;
    out_stall     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_MID;
    cfg_data      = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    words_sent    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words on the reset settings first.
    send_word(10'd0, 1'b0);
    send_word(10'd1023, 1'b1);     // full swing
    send_word(10'd512, 1'b1);      // window that never leaves the midpoint
    send_word(10'd1023, 1'b0);
    send_word(10'd0, 1'b0);
    send_word(10'd700, 1'b1);
    send_word(10'd513, 1'b1);      // half swing rounds down to nothing
    settle();

    // Zero count acts as one; trigger level eats the whole swing.
    set_config(0, 511, 0, 65535);
    send_word(10'd1023, 1'b1);
    settle();

    // Count above the range, maximum gain: saturate, then fall under the trigger.
    set_config(0, 100, 255, 65535);
    send_word(10'd1023, 1'b1);
    send_word(10'd150, 1'b1);
    settle();

    // Zero gain; leave three windows summed towards a four-window reading.
    set_config(1023, 0, 4, 0);
    send_word(10'd0, 1'b1);
    send_word(10'd1000, 1'b1);
    send_word(10'd1, 1'b1);
    settle();

    // Lower the count below what is already summed: the next window end reports.
    set_config(1023, 0, 2, 512);
    send_word(10'd1023, 1'b1);
    settle();

    // Move the midpoint with a window half done; the open window keeps its bounds.
    set_config(1023, 0, 1, 256);
    send_word(10'd600, 1'b0);
    send_word(10'd620, 1'b0);
    settle();
    set_config(0, 0, 1, 256);
    send_word(10'd610, 1'b1);
    send_word(10'd0, 1'b1);
    settle();

    // Back-pressure: hold the receiver off while every word closes a reading,
    // so the queue fills and the input stalls.
    set_config(512, 0, 1, 256);
    stall_pct = 81;
    hold_left = 600;
    for (int i = 0; i < 30; i++) send_word(ADC_BITS'($urandom_range(1023)), 1'b1);
    settle();

    // Random phases, cycling through the idling modes.
    phase = 0;
    while (words_sent < 1880) begin
      case (phase % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 81; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 81; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      random_config();
      phase_words = 0;
      while (phase_words < 155) begin
        if ($urandom_range(99) < 85) begin
          phase_words -= words_sent;
          send_window();
          phase_words += words_sent;
        end else begin
          // noise: any code, window end at random
          send_word(ADC_BITS'($urandom_range(1023)), 1'($urandom_range(1)));
          phase_words++;
        end
      end
      settle();
      phase++;
    end

    in_valid <= 1'b0;
    while (sb.readings_due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (sb.readings_due.size() != 0) begin
      sb.mismatches += sb.readings_due.size();
      $display("%0d readings never arrived", sb.readings_due.size());
    end

    $display("covered %0d sample words, %0d window ends, %0d random phases",
             sb.words_in, sb.window_ends, phase);
    $display("readings checked: %0d (%0d saturated, %0d zero), mismatches: %0d",
             sb.readings_out, sb.saturated, sb.zero_readings, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
